FILE: hdl/canny_edge_pixel_stream_unit_macros.svh
// Assertion macros for the RTL. Each use stands on a line of its own,
// with no trailing semicolon.
`ifndef CANNY_EDGE_PIXEL_STREAM_UNIT_MACROS_SVH
`define CANNY_EDGE_PIXEL_STREAM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// ante true at an edge implies cons true at the same edge
`define CEPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ceps assertion failed");

// ante true at an edge implies cons true at the following edge
`define CEPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ceps assertion failed");

`else

`define CEPS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define CEPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/ceps_pkg.sv
`default_nettype none

package ceps_pkg;

    localparam int unsigned CEPS_MAX_WIDTH = 1024;

    localparam int PIX_W  = 8;
    localparam int OUT_DW = 16;
    localparam int TAG_W  = 3;
    localparam int SEC_W  = 2;

    // tag bit positions
    localparam int TAG_VALID_B = 0;
    localparam int TAG_INNER_B = 1;
    localparam int TAG_LAST_B  = 2;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 12;
    localparam logic [CFG_AW-1:0] CFG_LOW    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_HIGH   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 3'd3;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    // gradient direction sectors
    localparam logic [SEC_W-1:0] SEC_HORZ     = 2'd0;
    localparam logic [SEC_W-1:0] SEC_DIAG_POS = 2'd1;
    localparam logic [SEC_W-1:0] SEC_VERT     = 2'd2;
    localparam logic [SEC_W-1:0] SEC_DIAG_NEG = 2'd3;

    // which ring read is issued this cycle
    typedef enum logic [2:0] {
        RD_NONE,
        RD_GAUSS,
        RD_SOBEL,
        RD_CTR,
        RD_NB0,
        RD_NB1
    } rd_kind_t;

    typedef struct packed {
        logic       take;
        logic       wr_in;
        rd_kind_t   rd;
        logic [1:0] win_r;
        logic [1:0] win_c;
        logic       first;
        logic       wr_smooth;
        logic       square;
        logic       sqrt_step;
        logic [2:0] sqrt_idx;
        logic       wr_mag;
        logic       finish;
    } ceps_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ceps_sts_t;

endpackage

`default_nettype wire

FILE: hdl/ceps_ram.sv
`default_nettype none

module ceps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/ceps_ctrl.sv
`default_nettype none
`include "canny_edge_pixel_stream_unit_macros.svh"

module ceps_ctrl import ceps_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire ceps_sts_t sts,
    output ceps_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR,
        ST_GAUSS,
        ST_GDRAIN,
        ST_GWR,
        ST_SOBEL,
        ST_SDRAIN,
        ST_SQUARE,
        ST_SQRT,
        ST_MWR,
        ST_CTR,
        ST_CWAIT,
        ST_NB0,
        ST_NB1,
        ST_NWAIT,
        ST_FIN
    } state_t;

    state_t     state_reg;
    logic [1:0] win_r_reg;
    logic [1:0] win_c_reg;
    logic [2:0] sqrt_reg;
    logic       win_done;

    assign win_done = (win_r_reg == 2'd2) && (win_c_reg == 2'd2);
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_r_reg <= '0;
            win_c_reg <= '0;
            sqrt_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    win_r_reg <= '0;
                    win_c_reg <= '0;
                    state_reg <= ST_GAUSS;
                end
                ST_GAUSS, ST_SOBEL: begin
                    if (win_done) begin
                        win_r_reg <= '0;
                        win_c_reg <= '0;
                        state_reg <= (state_reg == ST_GAUSS) ? ST_GDRAIN : ST_SDRAIN;
                    end else if (win_c_reg == 2'd2) begin
                        win_c_reg <= '0;
                        win_r_reg <= win_r_reg + 2'd1;
                    end else begin
                        win_c_reg <= win_c_reg + 2'd1;
                    end
                end
                ST_GDRAIN: state_reg <= ST_GWR;
                ST_GWR:    state_reg <= ST_SOBEL;
                ST_SDRAIN: state_reg <= ST_SQUARE;
                ST_SQUARE: begin
                    sqrt_reg  <= 3'd7;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sqrt_reg == 3'd0) begin
                        state_reg <= ST_MWR;
                    end else begin
                        sqrt_reg <= sqrt_reg - 3'd1;
                    end
                end
                ST_MWR:   state_reg <= ST_CTR;
                ST_CTR:   state_reg <= ST_CWAIT;
                ST_CWAIT: state_reg <= ST_NB0;
                ST_NB0:   state_reg <= ST_NB1;
                ST_NB1:   state_reg <= ST_NWAIT;
                ST_NWAIT: state_reg <= ST_FIN;
                ST_FIN: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.rd        = RD_NONE;
        cmd.win_r     = win_r_reg;
        cmd.win_c     = win_c_reg;
        cmd.first     = (win_r_reg == 2'd0) && (win_c_reg == 2'd0);
        cmd.sqrt_idx  = sqrt_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.take      = s_tvalid;
            ST_WR:     cmd.wr_in     = 1'b1;
            ST_GAUSS:  cmd.rd        = RD_GAUSS;
            ST_GWR:    cmd.wr_smooth = 1'b1;
            ST_SOBEL:  cmd.rd        = RD_SOBEL;
            ST_SQUARE: cmd.square    = 1'b1;
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_MWR:    cmd.wr_mag    = 1'b1;
            ST_CTR:    cmd.rd        = RD_CTR;
            ST_NB0:    cmd.rd        = RD_NB0;
            ST_NB1:    cmd.rd        = RD_NB1;
            ST_FIN:    cmd.finish    = !sts.out_busy;
            default:   cmd.take      = 1'b0;
        endcase
    end

    // a finished result never lands on one still waiting
    `CEPS_ASSERT_SAME(a_fin_free, aclk, aresetn, cmd.finish, !sts.out_busy)
    // the ring write follows the accepted item directly
    `CEPS_ASSERT_NEXT(a_take_write, aclk, aresetn, cmd.take, cmd.wr_in && !s_tready)
    // once the result is handed over the block takes items again
    `CEPS_ASSERT_NEXT(a_fin_ready, aclk, aresetn, cmd.finish, s_tready)
    // sqrt steps only ever follow the squaring cycle or another step
    `CEPS_ASSERT_SAME(a_sqrt_seq, aclk, aresetn, cmd.sqrt_step,
                      $past(cmd.square) || $past(cmd.sqrt_step))

endmodule

`default_nettype wire

FILE: hdl/ceps_datapath.sv
`default_nettype none

module ceps_datapath import ceps_pkg::*; #(
    parameter int MAX_WIDTH = CEPS_MAX_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ceps_cmd_t         cmd,
    output ceps_sts_t              sts,
    input  wire logic [PIX_W-1:0]  in_pixel,
    input  wire logic              in_flush,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [OUT_DW-1:0]      m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int RING_AW    = $clog2(4 * MAX_WIDTH);
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int WW         = $clog2(MAX_WIDTH + 1);

    typedef logic [RING_AW-1:0] addr_t;

    // configuration
    logic [7:0]  low_reg, high_reg;
    logic [10:0] width_reg;
    logic [11:0] height_reg;

    // frame position and ring bookkeeping
    logic [WW-1:0]    col_reg;
    logic [11:0]      row_reg;
    addr_t            head_reg;
    logic [RING_AW:0] fill_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [TAG_W-1:0] tag_reg;

    logic [12:0]   wid13, eff13;
    logic [WW-1:0] eff_w;
    logic [11:0]   eff_h;

    always_comb begin
        wid13 = {2'b0, width_reg};
        if (wid13 < 13'd8) begin
            eff13 = 13'd8;
        end else if (wid13 > 13'(MAX_WIDTH)) begin
            eff13 = 13'(MAX_WIDTH);
        end else begin
            eff13 = wid13;
        end
        eff_w = eff13[WW-1:0];
        eff_h = (height_reg < 12'd8) ? 12'd8 : height_reg;
    end

    // lags from the newest slot
    addr_t w_a, lag_w1, lag_w2, lag_2w, lag_2w2, lag_3w3;
    assign w_a     = addr_t'(eff_w);
    assign lag_w1  = w_a + addr_t'(1);
    assign lag_w2  = w_a + addr_t'(2);
    assign lag_2w  = w_a << 1;
    assign lag_2w2 = lag_2w + addr_t'(2);
    assign lag_3w3 = lag_2w2 + lag_w1;

    // window position of the next input item
    logic [WW:0] c_p1, c_p3, w_ext;
    logic [12:0] r_p1, r_p3, h_ext;
    logic        in_inner, in_last;

    assign c_p1  = {1'b0, col_reg} + (WW+1)'(1);
    assign c_p3  = {1'b0, col_reg} + (WW+1)'(3);
    assign w_ext = {1'b0, eff_w};
    assign r_p1  = {1'b0, row_reg} + 13'd1;
    assign r_p3  = {1'b0, row_reg} + 13'd3;
    assign h_ext = {1'b0, eff_h};
    assign in_inner = (row_reg != 12'd0) && (r_p3 <= h_ext) &&
                      (col_reg != '0) && (c_p3 <= w_ext);
    assign in_last  = (r_p1 == h_ext) && (c_p1 == w_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= '0;
            high_reg   <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
        end else begin
            if (cmd.take) begin
                head_reg <= head_reg + addr_t'(1);
                if (fill_reg != (RING_AW+1)'(RING_DEPTH)) begin
                    fill_reg <= fill_reg + (RING_AW+1)'(1);
                end
                if (!in_flush) begin
                    if (c_p1 >= w_ext) begin
                        col_reg <= '0;
                        row_reg <= (r_p1 >= h_ext) ? 12'd0 : r_p1[11:0];
                    end else begin
                        col_reg <= c_p1[WW-1:0];
                    end
                end
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_LOW:  low_reg  <= cfg_wdata[7:0];
                    CFG_HIGH: high_reg <= cfg_wdata[7:0];
                    CFG_WIDTH: begin
                        width_reg <= cfg_wdata[10:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    CFG_HEIGHT: begin
                        height_reg <= cfg_wdata[11:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default: low_reg <= low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg <= in_flush ? '0 : in_pixel;
            tag_reg <= in_flush ? '0 : {in_last, in_inner, 1'b1};
        end
    end

    // read address selection
    logic [SEC_W-1:0] sec_reg;
    addr_t row_lag, win_lag, nb0_lag, nb1_lag, main_lag, tag_lag, rd_addr, tag_addr;
    logic  tag_rd, main_oob, tag_oob;

    always_comb begin
        unique case (cmd.win_r)
            2'd0:    row_lag = lag_2w2;
            2'd1:    row_lag = lag_w2;
            default: row_lag = addr_t'(2);
        endcase
        win_lag = row_lag - addr_t'(cmd.win_c);

        unique case (sec_reg)
            SEC_HORZ: begin
                nb0_lag = lag_w2;
                nb1_lag = w_a;
            end
            SEC_DIAG_POS: begin
                nb0_lag = addr_t'(2);
                nb1_lag = lag_2w;
            end
            SEC_VERT: begin
                nb0_lag = addr_t'(1);
                nb1_lag = lag_2w + addr_t'(1);
            end
            default: begin
                nb0_lag = lag_2w2;
                nb1_lag = '0;
            end
        endcase

        unique case (cmd.rd)
            RD_GAUSS, RD_SOBEL: main_lag = win_lag;
            RD_CTR:             main_lag = lag_w1;
            RD_NB0:             main_lag = nb0_lag;
            RD_NB1:             main_lag = nb1_lag;
            default:            main_lag = '0;
        endcase

        unique case (cmd.rd)
            RD_GAUSS: tag_lag = lag_w1;
            RD_SOBEL: tag_lag = lag_2w2;
            RD_CTR:   tag_lag = lag_3w3;
            default:  tag_lag = '0;
        endcase
    end

    assign tag_rd   = (cmd.first && (cmd.rd == RD_GAUSS || cmd.rd == RD_SOBEL)) ||
                      (cmd.rd == RD_CTR);
    assign rd_addr  = head_reg - main_lag;
    assign tag_addr = head_reg - tag_lag;
    // slots never written since reset read as zero
    assign main_oob = {1'b0, main_lag} >= fill_reg;
    assign tag_oob  = {1'b0, tag_lag} >= fill_reg;

    // rings
    logic [PIX_W-1:0]       gray_q, smooth_q, smooth_wd;
    logic [TAG_W-1:0]       tag_q;
    logic [SEC_W+PIX_W-1:0] magsec_q, magsec_wd;

    ceps_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_gray (
        .aclk(aclk), .we(cmd.wr_in), .waddr(head_reg), .wdata(pix_reg),
        .raddr(rd_addr), .rdata(gray_q)
    );
    ceps_ram #(.WIDTH(TAG_W), .DEPTH(RING_DEPTH)) u_tag (
        .aclk(aclk), .we(cmd.wr_in), .waddr(head_reg), .wdata(tag_reg),
        .raddr(tag_addr), .rdata(tag_q)
    );
    ceps_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_smooth (
        .aclk(aclk), .we(cmd.wr_smooth), .waddr(head_reg), .wdata(smooth_wd),
        .raddr(rd_addr), .rdata(smooth_q)
    );
    ceps_ram #(.WIDTH(SEC_W+PIX_W), .DEPTH(RING_DEPTH)) u_magsec (
        .aclk(aclk), .we(cmd.wr_mag), .waddr(head_reg), .wdata(magsec_wd),
        .raddr(rd_addr), .rdata(magsec_q)
    );

    // read data is registered and arrives in the cycle after the address
    rd_kind_t   pend_kind_reg, tag_pend_reg;
    logic [1:0] pend_r_reg, pend_c_reg;
    logic       pend_oob_reg, tag_oob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_kind_reg <= RD_NONE;
            tag_pend_reg  <= RD_NONE;
        end else begin
            pend_kind_reg <= cmd.rd;
            tag_pend_reg  <= tag_rd ? cmd.rd : RD_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        pend_r_reg   <= cmd.win_r;
        pend_c_reg   <= cmd.win_c;
        pend_oob_reg <= main_oob;
        tag_oob_reg  <= tag_oob;
    end

    logic [PIX_W-1:0]       gdata, sdata;
    logic [TAG_W-1:0]       tdata;
    logic [SEC_W+PIX_W-1:0] mdata;

    assign gdata = pend_oob_reg ? '0 : gray_q;
    assign sdata = pend_oob_reg ? '0 : smooth_q;
    assign mdata = pend_oob_reg ? '0 : magsec_q;
    assign tdata = tag_oob_reg  ? '0 : tag_q;

    // Gaussian and Sobel accumulators
    logic [11:0]        sum_reg, gterm;
    logic [1:0]         gshift;
    logic signed [10:0] gx_reg, gy_reg, vx, vy;
    logic               g_inner_reg, s_inner_reg;

    assign gshift = {1'b0, pend_r_reg == 2'd1} + {1'b0, pend_c_reg == 2'd1};
    assign gterm  = {4'b0, gdata} << gshift;
    assign vx = $signed({2'b0, (pend_r_reg == 2'd1) ? {sdata, 1'b0} : {1'b0, sdata}});
    assign vy = $signed({2'b0, (pend_c_reg == 2'd1) ? {sdata, 1'b0} : {1'b0, sdata}});
    assign smooth_wd = g_inner_reg ? sum_reg[11:4] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.rd == RD_GAUSS && cmd.first) begin
            sum_reg <= '0;
        end else if (pend_kind_reg == RD_GAUSS) begin
            sum_reg <= sum_reg + gterm;
        end

        if (cmd.rd == RD_SOBEL && cmd.first) begin
            gx_reg <= '0;
            gy_reg <= '0;
        end else if (pend_kind_reg == RD_SOBEL) begin
            unique case (pend_c_reg)
                2'd0:    gx_reg <= gx_reg - vx;
                2'd2:    gx_reg <= gx_reg + vx;
                default: gx_reg <= gx_reg;
            endcase
            unique case (pend_r_reg)
                2'd0:    gy_reg <= gy_reg - vy;
                2'd2:    gy_reg <= gy_reg + vy;
                default: gy_reg <= gy_reg;
            endcase
        end

        if (tag_pend_reg == RD_GAUSS) begin
            g_inner_reg <= tdata[TAG_INNER_B];
        end
        if (tag_pend_reg == RD_SOBEL) begin
            s_inner_reg <= tdata[TAG_INNER_B];
        end
    end

    // squares for magnitude and the tangent compares
    logic [9:0]  ax, ay;
    logic [10:0] axy;
    logic [9:0]  dxy;
    logic [19:0] axx, ayy;
    logic [20:0] sq_reg, t2_reg;
    logic [21:0] p_reg;
    logic [19:0] q_reg;
    logic        gx_zero_reg, same_reg;
    logic [7:0]  root_reg, root_try;
    logic [15:0] root_sq;

    assign ax  = gx_reg[10] ? 10'(-gx_reg) : gx_reg[9:0];
    assign ay  = gy_reg[10] ? 10'(-gy_reg) : gy_reg[9:0];
    assign axy = {1'b0, ax} + {1'b0, ay};
    assign dxy = ay - ax;
    assign axx = 20'(ax) * 20'(ax);
    assign ayy = 20'(ay) * 20'(ay);
    assign root_try = root_reg | (8'd1 << cmd.sqrt_idx);
    assign root_sq  = 16'(root_try) * 16'(root_try);

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_reg      <= {1'b0, axx} + {1'b0, ayy};
            t2_reg      <= {axx, 1'b0};
            p_reg       <= 22'(axy) * 22'(axy);
            q_reg       <= (ay > ax) ? 20'(dxy) * 20'(dxy) : '0;
            gx_zero_reg <= (gx_reg == '0);
            same_reg    <= ((!gx_reg[10]) && (gx_reg != '0)) ==
                           ((!gy_reg[10]) && (gy_reg != '0));
            root_reg    <= '0;
        end else if (cmd.sqrt_step) begin
            if ({5'b0, root_sq} <= sq_reg) begin
                root_reg <= root_try;
            end
        end
    end

    logic [PIX_W-1:0] mag_val;
    logic [SEC_W-1:0] sec_val;

    always_comb begin
        mag_val = (sq_reg[20:16] != '0) ? 8'hFF : root_reg;
        if (gx_zero_reg) begin
            sec_val = SEC_VERT;
        end else if (p_reg < {1'b0, t2_reg}) begin
            sec_val = SEC_HORZ;
        end else if ({1'b0, q_reg} > t2_reg) begin
            sec_val = SEC_VERT;
        end else begin
            sec_val = same_reg ? SEC_DIAG_POS : SEC_DIAG_NEG;
        end
    end

    assign magsec_wd = s_inner_reg ? {sec_val, mag_val} : '0;

    // suppression
    logic [PIX_W-1:0] m_reg, n0_reg, n1_reg, fin;
    logic [TAG_W-1:0] otag_reg;

    always_ff @(posedge aclk) begin
        if (tag_pend_reg == RD_CTR) begin
            otag_reg <= tdata;
        end
        if (pend_kind_reg == RD_CTR) begin
            m_reg   <= mdata[PIX_W-1:0];
            sec_reg <= mdata[SEC_W+PIX_W-1:PIX_W];
        end
        if (pend_kind_reg == RD_NB0) begin
            n0_reg <= mdata[PIX_W-1:0];
        end
        if (pend_kind_reg == RD_NB1) begin
            n1_reg <= mdata[PIX_W-1:0];
        end
    end

    assign fin = (otag_reg[TAG_INNER_B] && (m_reg > n0_reg) && (m_reg > n1_reg)) ?
                 m_reg : '0;

    // output register
    logic             out_valid_reg;
    logic             out_edge_reg, out_res_reg, out_last_reg;
    logic [PIX_W-1:0] out_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_res_reg  <= otag_reg[TAG_VALID_B];
            out_last_reg <= otag_reg[TAG_LAST_B];
            out_mag_reg  <= fin;
            out_edge_reg <= (fin > low_reg) && (fin < high_reg);
        end
    end

    assign sts.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DW-PIX_W-1)'(0), out_mag_reg, out_edge_reg};
    assign m_tuser  = out_res_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hdl/canny_edge_pixel_stream_unit.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tdata: pixel; s_tuser: flush
// m_        out        m_tvalid / m_tready    m_tdata: edge_res, magnitude;
//                                             m_tuser: valid_res; m_tlast: last_of_frame
// cfg_      in         cfg_wr_en              cfg_addr index, cfg_wdata value
//
// An item is worked through from acceptance until its result is loaded before
// a new item is accepted; the sequencer walks one read per cycle through each
// 3x3 window (9 gray reads, 9 smoothed reads), then an 8-step bit-serial square
// root and the suppression reads, all on single-read-port line rings.
// Reset is synchronous, active low; the rings need no clearing pass, a fill
// count makes never-written slots read as zero.
// The next item is accepted while a finished result waits in the output
// register; the block stalls only when a second result is ready before the
// first is taken.
`default_nettype none

module canny_edge_pixel_stream_unit import ceps_pkg::*; #(
    parameter int MAX_WIDTH = CEPS_MAX_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // item in
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  s_tdata,   // [7:0] pixel
    input  wire logic              s_tuser,   // [0] flush
    // result out
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,   // [0] edge_res, [8:1] magnitude, rest zero
    output logic                   m_tuser,   // [0] valid_res
    output logic                   m_tlast,   // last_of_frame
    // register writes
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata
);

    ceps_cmd_t cmd;
    ceps_sts_t sts;

    // sequencer: steps an item through its states
    ceps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // config registers, rings, accumulators, sqrt, suppression and output register
    ceps_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_pixel  (s_tdata),
        .in_flush  (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
